/* hdl/smasu_pkg.sv */
// ----------------------------------------------------------------------------
// smasu_pkg
// shared types, constants and saturation helpers of the sma stress update
// ----------------------------------------------------------------------------
package smasu_pkg;

    localparam int STRAIN_FRAC_BITS_DEF = 30;
    localparam int FRACTION_BITS        = 16;
    localparam int MW                   = 56;

    typedef logic signed [MW-1:0] wide_t;

    localparam wide_t INNER_LIM  = 56'sh0FFFFFFFFFFFFF;
    localparam wide_t STRESS_MAX = 56'sd549755813887;
    localparam wide_t STRESS_MIN = -56'sd549755813888;
    localparam wide_t FRAC_MAX   = 56'sd131071;
    localparam wide_t FRAC_MIN   = -56'sd131072;
    localparam wide_t ONE_FRAC   = 56'sd65536;

    localparam logic [38:0] ELASTIC_RESET = 39'd4587520000;
    localparam logic [29:0] TSTRAIN_RESET = 30'd64424509;
    localparam logic [38:0] FS_RESET      = 39'd34406400;
    localparam logic [38:0] FF_RESET      = 39'd39321600;
    localparam logic [38:0] RS_RESET      = 39'd16384000;
    localparam logic [38:0] RF_RESET      = 39'd9830400;

    localparam logic [1:0] KIND_TRIAL  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_REVERT = 2'd2;

    localparam logic [2:0] REG_ELASTIC = 3'd0;
    localparam logic [2:0] REG_TSTRAIN = 3'd1;
    localparam logic [2:0] REG_FS      = 3'd2;
    localparam logic [2:0] REG_FF      = 3'd3;
    localparam logic [2:0] REG_RS      = 3'd4;
    localparam logic [2:0] REG_RF      = 3'd5;

    // divisor selection of the shared unit
    localparam logic [1:0] MU_STRAIN = 2'd0;
    localparam logic [1:0] MU_FRAC   = 2'd1;
    localparam logic [1:0] MU_DIV    = 2'd2;

    typedef struct packed {
        wide_t      a;
        wide_t      b;
        wide_t      d;
        logic [1:0] mode;
    } mu_req_t;

    typedef struct packed {
        logic [38:0] e;
        logic [29:0] l;
        logic [38:0] fs;
        logic [38:0] ff;
        logic [38:0] rs;
        logic [38:0] rf;
    } cfg_t;

    typedef struct packed {
        logic signed [17:0] fraction;
        logic signed [39:0] tangent;
        logic signed [39:0] stress;
    } res_t;

    function automatic wide_t inner_sat(input wide_t x);
        wide_t r;
        if (x > INNER_LIM)
            r = INNER_LIM;
        else if (x < -INNER_LIM)
            r = -INNER_LIM;
        else
            r = x;
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input wide_t x);
        wide_t r;
        if (x > STRESS_MAX)
            r = STRESS_MAX;
        else if (x < STRESS_MIN)
            r = STRESS_MIN;
        else
            r = x;
        return r[39:0];
    endfunction

    function automatic logic signed [17:0] sat18(input wide_t x);
        wide_t r;
        if (x > FRAC_MAX)
            r = FRAC_MAX;
        else if (x < FRAC_MIN)
            r = FRAC_MIN;
        else
            r = x;
        return r[17:0];
    endfunction

endpackage

/* hdl/smasu_muldiv.sv */
// ----------------------------------------------------------------------------
// smasu_muldiv
// shared a*b/d unit: bit-serial multiply, then constant shift or restoring
// divide, magnitudes truncated, saturated to the inner limit
// ----------------------------------------------------------------------------
module smasu_muldiv
    import smasu_pkg::*;
#(
    parameter int STRAIN_FRAC_BITS = STRAIN_FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  mu_req_t req,
    output logic    done,
    output wide_t   res
);

    localparam int CNT_W = $clog2(2 * MW);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MW - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(2 * MW - 1);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2*MW-1:0]   qr_reg, qr_next;
    logic [MW-1:0]     bm_reg, bm_next;
    logic [MW-1:0]     dm_reg, dm_next;
    logic [MW-1:0]     rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic              dneg_reg, dneg_next;
    logic              dz_reg, dz_next;
    logic [1:0]        mode_reg, mode_next;
    logic              done_reg, done_next;
    wide_t             res_reg, res_next;

    logic [MW-1:0]     am, bm, dm;
    logic [MW:0]       msum;
    logic [MW:0]       r2;
    logic              ge;
    logic [MW:0]       rdiff;
    logic [2*MW-1:0]   qsrc;
    wide_t             qsat;
    logic              negf;

    always_comb
    begin
        am    = req.a[MW-1] ? MW'(-req.a) : MW'(req.a);
        bm    = req.b[MW-1] ? MW'(-req.b) : MW'(req.b);
        dm    = req.d[MW-1] ? MW'(-req.d) : MW'(req.d);
        msum  = {1'b0, qr_reg[2*MW-1:MW]} + (qr_reg[0] ? {1'b0, bm_reg} : '0);
        r2    = {rem_reg, qr_reg[2*MW-1]};
        ge    = r2 >= {1'b0, dm_reg};
        rdiff = r2 - {1'b0, dm_reg};
        unique case (mode_reg)
            MU_STRAIN: qsrc = qr_reg >> STRAIN_FRAC_BITS;
            MU_FRAC:   qsrc = qr_reg >> FRACTION_BITS;
            default:   qsrc = qr_reg;
        endcase
        if (qsrc > {{MW{1'b0}}, INNER_LIM})
            qsat = INNER_LIM;
        else
            qsat = qsrc[MW-1:0];
        negf = neg_reg ^ ((mode_reg == MU_DIV) && dneg_reg);
        if ((mode_reg == MU_DIV) && dz_reg)
        begin
            qsat = INNER_LIM;
            negf = neg_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        qr_next    = qr_reg;
        bm_next    = bm_reg;
        dm_next    = dm_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        dneg_next  = dneg_reg;
        dz_next    = dz_reg;
        mode_next  = mode_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    qr_next    = {{MW{1'b0}}, am};
                    bm_next    = bm;
                    dm_next    = dm;
                    neg_next   = (req.a[MW-1] != req.b[MW-1]) && (req.a != '0)
                                 && (req.b != '0);
                    dneg_next  = req.d[MW-1];
                    dz_next    = req.d == '0;
                    mode_next  = req.mode;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                qr_next  = {msum, qr_reg[MW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if ((mode_reg == MU_DIV) && !dz_reg)
                        state_next = U_DIV;
                    else
                        state_next = U_OUT;
                end
            end
            U_DIV:
            begin
                rem_next = ge ? rdiff[MW-1:0] : r2[MW-1:0];
                qr_next  = {qr_reg[2*MW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = U_OUT;
            end
            default:
            begin
                res_next   = negf ? -qsat : qsat;
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg   <= qr_next;
        bm_reg   <= bm_next;
        dm_reg   <= dm_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        dneg_reg <= dneg_next;
        dz_reg   <= dz_next;
        mode_reg <= mode_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* hdl/smasu_seq.sv */
// ----------------------------------------------------------------------------
// smasu_seq
// sequencer: holds trial and committed state, picks the branch and issues
// the products and quotients to the shared unit one after another
// ----------------------------------------------------------------------------
module smasu_seq
    import smasu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         kind,
    input  logic signed [31:0] strain,
    input  cfg_t               cfg,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               mu_start,
    output mu_req_t            mu_req,
    input  logic               mu_done,
    input  wide_t              mu_res
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_EP   = 5'd1;
    localparam logic [4:0] S_EL   = 5'd2;
    localparam logic [4:0] S_CEL  = 5'd3;
    localparam logic [4:0] S_CHK1 = 5'd4;
    localparam logic [4:0] S_CHK2 = 5'd5;
    localparam logic [4:0] S_LG   = 5'd6;
    localparam logic [4:0] S_LM1  = 5'd7;
    localparam logic [4:0] S_LM2  = 5'd8;
    localparam logic [4:0] S_LDEN = 5'd9;
    localparam logic [4:0] S_LFR  = 5'd10;
    localparam logic [4:0] S_UDEN = 5'd11;
    localparam logic [4:0] S_UFR  = 5'd12;
    localparam logic [4:0] S_ST   = 5'd13;
    localparam logic [4:0] S_TG   = 5'd14;
    localparam logic [4:0] S_FIN  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0]         state_reg;
    logic               wait_reg;
    logic               tension_reg, loading_reg;

    logic signed [31:0] c_strain_reg, t_strain_reg;
    logic signed [39:0] c_stress_reg, t_stress_reg, t_tangent_reg;
    logic signed [17:0] c_frac_reg, t_frac_reg;

    wide_t              ep_reg, el_reg, cel_reg, num_reg, den_reg, gk_reg;
    wide_t              ms_reg, s0_reg, st_reg, tg_reg;
    logic signed [17:0] fr_reg;

    wide_t              e_w, l_w, fs_w, ff_w, rs_w, rf_w;
    wide_t              c_w, omc_w, tmag_w, s1_w;
    logic signed [32:0] dlt;
    logic               is_call;
    logic signed [39:0] st40;

    always_comb
    begin
        e_w    = wide_t'(cfg.e);
        l_w    = wide_t'(cfg.l);
        fs_w   = wide_t'(cfg.fs);
        ff_w   = wide_t'(cfg.ff);
        rs_w   = wide_t'(cfg.rs);
        rf_w   = wide_t'(cfg.rf);
        c_w    = wide_t'(c_frac_reg);
        omc_w  = ONE_FRAC - c_w;
        tmag_w = tension_reg ? wide_t'(t_strain_reg) : -wide_t'(t_strain_reg);
        s1_w   = (ms_reg > rs_w) ? rs_w : ms_reg;
        dlt    = 33'(strain) - 33'(c_strain_reg);
        st40   = sat40(st_reg);
    end

    always_comb
    begin
        is_call     = 1'b1;
        mu_req.a    = '0;
        mu_req.b    = '0;
        mu_req.d    = den_reg;
        mu_req.mode = MU_FRAC;
        unique case (state_reg)
            S_EP:
            begin
                mu_req.a    = e_w;
                mu_req.b    = tmag_w;
                mu_req.mode = MU_STRAIN;
            end
            S_EL:
            begin
                mu_req.a    = e_w;
                mu_req.b    = l_w;
                mu_req.mode = MU_STRAIN;
            end
            S_CEL:
            begin
                mu_req.a = c_w;
                mu_req.b = el_reg;
            end
            S_LG:
            begin
                mu_req.a = omc_w;
                mu_req.b = el_reg;
            end
            S_LM1:
            begin
                mu_req.a = omc_w;
                mu_req.b = ep_reg;
            end
            S_LM2:
            begin
                mu_req.a = c_w;
                mu_req.b = ff_w;
            end
            S_LFR:
            begin
                mu_req.a    = num_reg;
                mu_req.b    = ONE_FRAC;
                mu_req.mode = MU_DIV;
            end
            S_UFR:
            begin
                mu_req.a    = c_w;
                mu_req.b    = num_reg;
                mu_req.mode = MU_DIV;
            end
            S_ST:
            begin
                mu_req.a = wide_t'(fr_reg);
                mu_req.b = el_reg;
            end
            S_TG:
            begin
                mu_req.a    = e_w;
                mu_req.b    = gk_reg;
                mu_req.mode = MU_DIV;
            end
            default:
            begin
                is_call = 1'b0;
            end
        endcase
    end

    assign mu_start = is_call && !wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            c_strain_reg  <= '0;
            c_stress_reg  <= '0;
            c_frac_reg    <= '0;
            t_strain_reg  <= '0;
            t_stress_reg  <= '0;
            t_frac_reg    <= '0;
            t_tangent_reg <= 40'(ELASTIC_RESET);
        end
        else
        begin
            if (mu_start)
                wait_reg <= 1'b1;
            else if (mu_done)
                wait_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DONE;
                        unique case (kind)
                            KIND_TRIAL:
                            begin
                                t_strain_reg <= strain;
                                tension_reg  <= !strain[31];
                                loading_reg  <= (dlt > 0) == !strain[31];
                                ms_reg       <= strain[31] ? -wide_t'(c_stress_reg)
                                                           : wide_t'(c_stress_reg);
                                if ((strain != '0) && (dlt != '0))
                                    state_reg <= S_EP;
                            end
                            KIND_COMMIT:
                            begin
                                c_strain_reg <= t_strain_reg;
                                c_stress_reg <= t_stress_reg;
                                c_frac_reg   <= t_frac_reg;
                            end
                            KIND_REVERT:
                            begin
                                c_strain_reg  <= '0;
                                c_stress_reg  <= '0;
                                c_frac_reg    <= '0;
                                t_strain_reg  <= '0;
                                t_stress_reg  <= '0;
                                t_frac_reg    <= '0;
                                t_tangent_reg <= 40'(cfg.e);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EP:
                begin
                    if (mu_done)
                    begin
                        ep_reg    <= mu_res;
                        state_reg <= S_EL;
                    end
                end
                S_EL:
                begin
                    if (mu_done)
                    begin
                        el_reg    <= mu_res;
                        state_reg <= S_CEL;
                    end
                end
                S_CEL:
                begin
                    if (mu_done)
                    begin
                        cel_reg   <= mu_res;
                        state_reg <= S_CHK1;
                    end
                end
                S_CHK1:
                begin
                    tg_reg <= e_w;
                    if (loading_reg)
                    begin
                        if (ep_reg <= inner_sat(fs_w + cel_reg))
                        begin
                            fr_reg    <= c_frac_reg;
                            st_reg    <= ep_reg - cel_reg;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_CHK2;
                    end
                    else
                    begin
                        if (ep_reg >= inner_sat(rs_w + cel_reg))
                        begin
                            fr_reg    <= c_frac_reg;
                            st_reg    <= ep_reg - cel_reg;
                            state_reg <= S_FIN;
                        end
                        else if (ep_reg >= rf_w)
                            state_reg <= S_UDEN;
                        else
                        begin
                            fr_reg    <= '0;
                            st_reg    <= ep_reg;
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_CHK2:
                begin
                    if (ep_reg < inner_sat(ff_w + el_reg))
                    begin
                        s0_reg    <= (ms_reg <= fs_w) ? fs_w : ms_reg;
                        state_reg <= S_LG;
                    end
                    else
                    begin
                        fr_reg    <= 18'(ONE_FRAC);
                        st_reg    <= ep_reg - el_reg;
                        state_reg <= S_FIN;
                    end
                end
                S_LG:
                begin
                    if (mu_done)
                    begin
                        gk_reg    <= mu_res;
                        state_reg <= S_LM1;
                    end
                end
                S_LM1:
                begin
                    if (mu_done)
                    begin
                        num_reg   <= mu_res;
                        state_reg <= S_LM2;
                    end
                end
                S_LM2:
                begin
                    if (mu_done)
                    begin
                        num_reg   <= inner_sat(num_reg + mu_res - s0_reg);
                        state_reg <= S_LDEN;
                    end
                end
                S_LDEN:
                begin
                    den_reg   <= inner_sat(gk_reg + ff_w - s0_reg);
                    state_reg <= S_LFR;
                end
                S_UDEN:
                begin
                    den_reg   <= inner_sat(cel_reg + s1_w - rf_w);
                    num_reg   <= ep_reg - rf_w;
                    gk_reg    <= cel_reg;
                    state_reg <= S_UFR;
                end
                S_LFR, S_UFR:
                begin
                    if (mu_done)
                    begin
                        fr_reg    <= sat18(mu_res);
                        state_reg <= S_ST;
                    end
                end
                S_ST:
                begin
                    if (mu_done)
                    begin
                        st_reg    <= ep_reg - mu_res;
                        state_reg <= S_TG;
                    end
                end
                S_TG:
                begin
                    if (mu_done)
                    begin
                        tg_reg    <= e_w - mu_res;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    t_frac_reg    <= fr_reg;
                    t_tangent_reg <= sat40(tg_reg);
                    // compression mirrors the stress back
                    t_stress_reg  <= tension_reg ? st40 : sat40(-wide_t'(st40));
                    state_reg     <= S_DONE;
                end
                default:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle         = state_reg == S_IDLE;
    assign res_valid    = state_reg == S_DONE;
    assign res.stress   = t_stress_reg;
    assign res.tangent  = t_tangent_reg;
    assign res.fraction = t_frac_reg;

endmodule

/* hdl/superelastic_sma_stress_update_top.sv */
// ----------------------------------------------------------------------------
// superelastic_sma_stress_update_top
// uniaxial superelastic shape-memory-alloy stress update, fixed point
// ----------------------------------------------------------------------------
// One item at a time. Commit, revert, unused kinds and trial strains that are
// zero or equal to the committed strain answer directly, without the shared
// unit. Other trial strains run through one shared multiply/divide unit: each
// product is a 56-step serial multiply, and each quotient is that multiply
// followed by a 112-step restoring divide. The result sits in an output
// register, so the next item may be taken while it waits.
module superelastic_sma_stress_update_top
    import smasu_pkg::*;
#(
    parameter int STRAIN_FRAC_BITS = STRAIN_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // strain_in
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // stress_out, tangent_out, fraction_out, zero fill
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [38:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    res_t    out_reg;

    logic    seq_idle, res_valid, res_ready;
    res_t    res;
    logic    mu_start, mu_done;
    mu_req_t mu_req;
    wide_t   mu_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.e  <= ELASTIC_RESET;
            cfg_reg.l  <= TSTRAIN_RESET;
            cfg_reg.fs <= FS_RESET;
            cfg_reg.ff <= FF_RESET;
            cfg_reg.rs <= RS_RESET;
            cfg_reg.rf <= RF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ELASTIC: cfg_reg.e  <= cfg_wdata;
                REG_TSTRAIN: cfg_reg.l  <= cfg_wdata[29:0];
                REG_FS:      cfg_reg.fs <= cfg_wdata;
                REG_FF:      cfg_reg.ff <= cfg_wdata;
                REG_RS:      cfg_reg.rs <= cfg_wdata;
                REG_RF:      cfg_reg.rf <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready  = seq_idle;
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.fraction, out_reg.tangent, out_reg.stress};

    smasu_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .kind      (s_tuser),
        .strain    (s_tdata),
        .cfg       (cfg_reg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mu_start  (mu_start),
        .mu_req    (mu_req),
        .mu_done   (mu_done),
        .mu_res    (mu_res)
    );

    smasu_muldiv #(
        .STRAIN_FRAC_BITS (STRAIN_FRAC_BITS)
    ) u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mu_start),
        .req   (mu_req),
        .done  (mu_done),
        .res   (mu_res)
    );

endmodule

/* sim/smasu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smasu_checker
// watches the configuration port and both streams of the sma stress update,
// predicts each result from its own copy of the material state and compares
// ----------------------------------------------------------------------------
module smasu_checker
    import smasu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,   // strain_in
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // stress_out, tangent_out, fraction_out, zero fill
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [38:0]  cfg_wdata,
    output int           errors,
    output int           outstanding
);

    localparam longint SAT_LIM  = (longint'(1) <<< 52) - 1;
    localparam longint S40_MAX  = (longint'(1) <<< 39) - 1;
    localparam longint S40_MIN  = -(longint'(1) <<< 39);
    localparam longint F18_MAX  = 131071;
    localparam longint F18_MIN  = -131072;
    localparam longint FRAC_ONE = longint'(1) <<< FRACTION_BITS;

    typedef struct {
        logic [39:0] stress;
        logic [39:0] tangent;
        logic [17:0] fraction;
    } sma_result_t;

    sma_result_t expected_results[$];

    // material constants
    longint mod_e, tr_strain, fwd_s, fwd_f, rev_s, rev_f;
    // committed and trial state
    longint com_strain, com_stress, com_frac;
    longint tri_strain, tri_stress, tri_frac, tri_tangent;

    assign outstanding = expected_results.size();

    function automatic longint clampv(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat52(longint x);
        return clampv(x, -SAT_LIM, SAT_LIM);
    endfunction

    // a*b/d on truncated magnitudes, saturated
    function automatic longint scaled_quot(longint a, longint b, longint d);
        bit          neg;
        logic [63:0] ma, mb, md;
        logic [127:0] q;
        neg = (a < 0) != (b < 0);
        if (a == 0 || b == 0)
            neg = 1'b0;
        if (d == 0)
            return neg ? -SAT_LIM : SAT_LIM;
        if (d < 0)
            neg = !neg;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        md = d < 0 ? -d : d;
        q = ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
        if (q > 128'(SAT_LIM))
            q = 128'(SAT_LIM);
        if (q == 0)
            return 0;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // tension-side branch on mirrored magnitudes
    task automatic update_branch(longint ep, bit loading, longint ms);
        longint c, el, cel, st, tg, fr, s0, s1, omc, g, num, den;
        c   = com_frac;
        el  = scaled_quot(mod_e, tr_strain, longint'(1) <<< STRAIN_FRAC_BITS_DEF);
        cel = scaled_quot(c, el, FRAC_ONE);
        tg  = mod_e;
        if (loading) begin
            if (ep <= sat52(fwd_s + cel)) begin
                fr = c;
                st = ep - cel;
            end
            else if (ep < sat52(fwd_f + el)) begin
                s0  = ms <= fwd_s ? fwd_s : ms;
                omc = FRAC_ONE - c;
                g   = scaled_quot(omc, el, FRAC_ONE);
                num = sat52(scaled_quot(omc, ep, FRAC_ONE)
                            + scaled_quot(c, fwd_f, FRAC_ONE) - s0);
                den = sat52(g + fwd_f - s0);
                fr  = clampv(scaled_quot(num, FRAC_ONE, den), F18_MIN, F18_MAX);
                st  = ep - scaled_quot(fr, el, FRAC_ONE);
                tg  = mod_e - scaled_quot(mod_e, g, den);
            end
            else begin
                fr = FRAC_ONE;
                st = ep - el;
            end
        end
        else begin
            if (ep >= sat52(rev_s + cel)) begin
                fr = c;
                st = ep - cel;
            end
            else if (ep >= rev_f) begin
                s1  = ms > rev_s ? rev_s : ms;
                den = sat52(cel + s1 - rev_f);
                fr  = clampv(scaled_quot(c, ep - rev_f, den), F18_MIN, F18_MAX);
                st  = ep - scaled_quot(fr, el, FRAC_ONE);
                tg  = mod_e - scaled_quot(mod_e, cel, den);
            end
            else begin
                fr = 0;
                st = ep;
            end
        end
        tri_frac    = fr;
        tri_stress  = clampv(st, S40_MIN, S40_MAX);
        tri_tangent = clampv(tg, S40_MIN, S40_MAX);
    endtask

    task automatic clear_material();
        com_strain = 0; com_stress = 0; com_frac = 0;
        tri_strain = 0; tri_stress = 0; tri_frac = 0;
        tri_tangent = mod_e;
    endtask

    task automatic predict_stress(logic [1:0] kind, logic [31:0] strain);
        longint      t, d, ep;
        bit          tension;
        sma_result_t r;
        if (kind == KIND_TRIAL) begin
            t = longint'($signed(strain));
            d = t - com_strain;
            tri_strain = t;
            if (t != 0 && d != 0) begin
                tension = t > 0;
                ep = scaled_quot(mod_e, tension ? t : -t,
                                 longint'(1) <<< STRAIN_FRAC_BITS_DEF);
                update_branch(ep, (d > 0) == tension, tension ? com_stress : -com_stress);
                if (!tension)
                    tri_stress = clampv(-tri_stress, S40_MIN, S40_MAX);
            end
        end
        else if (kind == KIND_COMMIT) begin
            com_strain = tri_strain;
            com_stress = tri_stress;
            com_frac   = tri_frac;
        end
        else if (kind == KIND_REVERT) begin
            clear_material();
        end
        r.stress   = tri_stress[39:0];
        r.tangent  = tri_tangent[39:0];
        r.fraction = tri_frac[17:0];
        expected_results.push_back(r);
    endtask

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sma_result_t r;
        if (!rst_n) begin
            errors    = 0;
            mod_e     = longint'(ELASTIC_RESET);
            tr_strain = longint'(TSTRAIN_RESET);
            fwd_s     = longint'(FS_RESET);
            fwd_f     = longint'(FF_RESET);
            rev_s     = longint'(RS_RESET);
            rev_f     = longint'(RF_RESET);
            clear_material();
            expected_results.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ELASTIC: mod_e     = longint'(cfg_wdata);
                    REG_TSTRAIN: tr_strain = longint'(cfg_wdata[29:0]);
                    REG_FS:      fwd_s     = longint'(cfg_wdata);
                    REG_FF:      fwd_f     = longint'(cfg_wdata);
                    REG_RS:      rev_s     = longint'(cfg_wdata);
                    REG_RF:      rev_f     = longint'(cfg_wdata);
                    default: ;
                endcase
            end
            // results belong to earlier transfers, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", m_tdata[39:0], '0);
                end
                else begin
                    r = expected_results.pop_front();
                    if (m_tdata[39:0] !== r.stress)
                        report("stress", m_tdata[39:0], r.stress);
                    if (m_tdata[79:40] !== r.tangent)
                        report("tangent", m_tdata[79:40], r.tangent);
                    if (m_tdata[97:80] !== r.fraction)
                        report("fraction", 40'(m_tdata[97:80]), 40'(r.fraction));
                end
            end
            if (s_tvalid && s_tready)
                predict_stress(s_tuser, s_tdata);
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives strain histories and material settings into the sma stress update
// ----------------------------------------------------------------------------
module tb_top;
    import smasu_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int PER_PHASE   = 190;
    localparam logic [38:0] MAX39 = {39{1'b1}};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // strain_in
    logic [1:0]   s_tuser = '0;   // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;        // stress_out, tangent_out, fraction_out, zero fill
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [38:0]  cfg_wdata = '0;

    int  errors, outstanding;
    int  sent_count = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    logic [31:0] last_strain = '0;

    always #5 clk = ~clk;

    superelastic_sma_stress_update_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    smasu_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .outstanding(outstanding)
    );

    // receiver, with one long hold-off so the input backs up
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** superelastic_sma_stress_update_top: FAILED **");
            $finish;
        end
    end

    task automatic send(logic [1:0] kind, logic [31:0] strain);
        if (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= strain;
        do @(posedge clk); while (!s_tready);
        if (kind == KIND_TRIAL)
            last_strain = strain;
        sent_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [38:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_material(logic [38:0] e, logic [29:0] l, logic [38:0] fs,
                                logic [38:0] ff, logic [38:0] rs, logic [38:0] rf);
        s_tvalid <= 1'b0;
        // let the checker see the last transfer before looking at the count
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        write_reg(REG_ELASTIC, e);
        write_reg(REG_TSTRAIN, 39'(l));
        write_reg(REG_FS, fs);
        write_reg(REG_FF, ff);
        write_reg(REG_RS, rs);
        write_reg(REG_RF, rf);
    endtask

    function automatic logic [38:0] rand39();
        return 39'({$urandom, $urandom});
    endfunction

    // load to a peak in one direction and unload, at times past zero, committing most steps
    task automatic strain_cycle();
        int    steps, k;
        longint peak, lo, v;
        bit    neg;
        neg   = ($urandom_range(0, 1) == 1);
        peak  = $urandom_range(1 << 20, 1 << 27);
        lo    = $urandom_range(0, 3) == 0 ? -longint'($urandom_range(0, 1 << 25)) : 0;
        steps = $urandom_range(3, 8);
        for (k = 1; k <= steps; k++) begin
            v = peak * k / steps;
            send(KIND_TRIAL, 32'(neg ? -v : v));
            if ($urandom_range(0, 99) < 80)
                send(KIND_COMMIT, '0);
        end
        for (k = steps - 1; k >= 0; k--) begin
            v = lo + (peak - lo) * k / steps;
            send(KIND_TRIAL, 32'(neg ? -v : v));
            if ($urandom_range(0, 99) < 80)
                send(KIND_COMMIT, '0);
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 5))
            0: send(KIND_TRIAL, $urandom);
            1: send(2'd3, $urandom);
            2: send(KIND_REVERT, $urandom);
            3: send(KIND_TRIAL, last_strain);
            4: send(KIND_TRIAL, '0);
            default: send(KIND_COMMIT, $urandom);
        endcase
    endtask

    task automatic random_phase(int target);
        while (sent_count < target) begin
            if ($urandom_range(0, 99) < 75)
                strain_cycle();
            else
                noise_item();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, all kinds, unchanged and zero strain, both branches
        send(KIND_TRIAL, '0);
        send(KIND_TRIAL, 32'h7FFF_FFFF);
        send(KIND_TRIAL, 32'h8000_0000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'h8000_0000);
        send(KIND_TRIAL, 32'h0000_0001);
        send(2'd3, 32'hFFFF_FFFF);
        send(KIND_REVERT, '0);
        send(KIND_TRIAL, 32'd5_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'd10_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'd40_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'd90_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'd30_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, 32'd8_000_000);
        send(KIND_REVERT, '0);
        send(KIND_TRIAL, -32'sd40_000_000);
        send(KIND_COMMIT, '0);
        send(KIND_TRIAL, -32'sd10_000_000);
        send(KIND_TRIAL, 32'hFFFF_FFFF);

        random_phase(PER_PHASE);
        hold_req = 1'b1;
        random_phase(2 * PER_PHASE);

        // extreme settings
        set_material(MAX39, {30{1'b1}}, '0, MAX39, MAX39, '0);
        random_phase(2 * PER_PHASE + 60);
        set_material(39'd1, '0, MAX39, '0, '0, MAX39);
        random_phase(2 * PER_PHASE + 120);

        steady = 1'b1;
        set_material(39'($urandom_range(20000, 120000)) << 16, 30'($urandom_range(0, 1 << 27)),
                     39'($urandom_range(200, 600)) << 16, 39'($urandom_range(500, 900)) << 16,
                     39'($urandom_range(150, 400)) << 16, 39'($urandom_range(0, 250)) << 16);
        random_phase(3 * PER_PHASE + 120);
        steady = 1'b0;

        set_material(rand39(), 30'($urandom), rand39() >> $urandom_range(0, 20),
                     rand39() >> $urandom_range(0, 20), rand39() >> $urandom_range(0, 20),
                     rand39() >> $urandom_range(0, 20));
        random_phase(4 * PER_PHASE + 120);

        set_material(ELASTIC_RESET, TSTRAIN_RESET, FS_RESET, FF_RESET, RS_RESET, RF_RESET);
        random_phase(6 * PER_PHASE);

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("** superelastic_sma_stress_update_top: PASSED **");
        else
            $display("** superelastic_sma_stress_update_top: FAILED **");
        $finish;
    end

endmodule
